[rtl/x86es_pkg.sv]
// ----------------------------------------------------------------------------
// x86es_pkg
// shared types, opcode constants and byte helpers for the execute step
// ----------------------------------------------------------------------------
package x86es_pkg;

  typedef logic [5:0][7:0] byte_vec_t;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_ACCEPT = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  // arithmetic kinds from the opcode or reg field
  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_SUB = 3'd5;
  localparam logic [2:0] ALU_CMP = 3'd7;

  // opcode group tags
  localparam logic [5:0] OP_MOV_RM  = 6'h22;
  localparam logic [6:0] OP_MOV_IMM = 7'h63;
  localparam logic [3:0] OP_MOV_RI  = 4'hB;
  localparam logic [5:0] OP_MOV_ACC = 6'h28;
  localparam logic [5:0] OP_ALU_IMM = 6'h20;
  localparam logic [3:0] OP_JCC     = 4'h7;
  localparam logic [3:0] OP_LOOP    = 4'hE;
  localparam logic [3:0] OP_JNE     = 4'h5;

  function automatic logic [7:0] pick(input byte_vec_t v, input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0: r = v[0];
      3'd1: r = v[1];
      3'd2: r = v[2];
      3'd3: r = v[3];
      3'd4: r = v[4];
      3'd5: r = v[5];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] sext8(input logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

endpackage

[rtl/x86_16bit_subset_execute_step.sv]
// ----------------------------------------------------------------------------
// x86_16bit_subset_execute_step
// executes one 16-bit real-mode instruction per input word, with a byte data
// store held in two byte-wide banks (even and odd addresses)
// ----------------------------------------------------------------------------
// a new word is taken only after the last result word has committed; a load
//   reads the data store in the accept cycle and writes the register file in
//   the finish cycle
// reset: registers, flags, pointer and cycle count clear at once; then all
//   2**(DATA_ADDR_BITS-1) rows of the data store are swept, input stalled meanwhile
module x86_16bit_subset_execute_step #(
  parameter int DATA_ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  opcode_byte,
  input  logic [7:0]  second_byte,
  input  logic [7:0]  third_byte,
  input  logic [7:0]  fourth_byte,
  input  logic [7:0]  fifth_byte,
  input  logic [7:0]  sixth_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] next_pointer,
  output logic [2:0]  length_used,
  output logic        reg_written,
  output logic [2:0]  reg_number,
  output logic [15:0] reg_value,
  output logic        sign_out,
  output logic        zero_out,
  output logic [31:0] cycle_total,
  output logic        unknown_opcode
);
  import x86es_pkg::*;

  localparam int ADDR_W = DATA_ADDR_BITS;
  localparam int ROW_W  = ADDR_W - 1;
  localparam int ROWS   = 2 ** ROW_W;

  // architectural state; pointer, flags and cycle count double as outputs
  state_t      st;
  logic [15:0] regs [8];

  // two byte banks: a word at a and a+1 always hits one byte in each
  logic [7:0]       bank_even [ROWS];
  logic [7:0]       bank_odd  [ROWS];
  logic [7:0]       even_rdata, odd_rdata;
  logic [ROW_W-1:0] clear_row;

  logic accept, out_free, commit;

  // decode signals
  byte_vec_t   bv;
  logic [7:0]  op;
  logic        d, w, direct;
  logic [1:0]  md, dl;
  logic [2:0]  rg, rm, ri, imm_pos;
  logic [15:0] disp, base, ea, imm_w, imm_rm, imm_acc;
  logic [7:0]  imm_lo, imm_hi;
  logic [3:0]  eac;
  logic [2:0]  len;
  logic [4:0]  cyc;
  logic        wr, load, store, unk, sign_n, zero_n;
  logic [2:0]  num;
  logic [15:0] val, st_data, jump;
  logic        alu_en;
  logic [2:0]  alu_kind, alu_dst;
  logic [15:0] alu_a, alu_b, alu_res;

  // memory addressing
  logic [ADDR_W-1:0] lo_addr, hi_addr;
  logic [ROW_W-1:0]  even_row, odd_row;
  logic              even_we, odd_we;
  logic [7:0]        even_wdata, odd_wdata;

  // finish stage holding registers
  logic        p_wr, p_load, p_a0, p_sign, p_zero, p_unk;
  logic [2:0]  p_num, p_len;
  logic [15:0] p_val, p_ptr;
  logic [4:0]  p_cyc;
  logic [15:0] load_val, wb_val;

  assign in_stall = (st != ST_ACCEPT);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign commit   = (st == ST_FINISH) && out_free;

  // ---------------------------------------------------------------- decode
  always_comb begin
    bv = {sixth_byte, fifth_byte, fourth_byte, third_byte, second_byte, opcode_byte};
    op = opcode_byte;
    d  = op[1];
    w  = op[0];
    md = second_byte[7:6];
    rg = second_byte[5:3];
    rm = second_byte[2:0];
    // byte registers fold onto the word registers
    ri = w ? rg : {1'b0, rg[1:0]};
    direct = (md == 2'd0) && (rm == 3'd6);
    if (md == 2'd1) begin
      dl = 2'd1;
    end else if (md == 2'd2 || direct) begin
      dl = 2'd2;
    end else begin
      dl = 2'd0;
    end
    unique case (dl)
      2'd1:    disp = sext8(third_byte);
      2'd2:    disp = {fourth_byte, third_byte};
      default: disp = 16'h0000;
    endcase
    unique case (rm)
      3'd0: base = regs[3] + regs[6];
      3'd1: base = regs[3] + regs[7];
      3'd2: base = regs[5] + regs[6];
      3'd3: base = regs[5] + regs[7];
      3'd4: base = regs[6];
      3'd5: base = regs[7];
      3'd6: base = regs[5];
      default: base = regs[3];
    endcase
    ea = direct ? disp : base + disp;
    // effective address timing
    if (direct) begin
      eac = 4'd6;
    end else if (rm == 3'd0 || rm == 3'd3) begin
      eac = (disp != 16'h0000) ? 4'd11 : 4'd7;
    end else if (rm == 3'd1 || rm == 3'd2) begin
      eac = (disp != 16'h0000) ? 4'd12 : 4'd8;
    end else begin
      eac = (disp != 16'h0000) ? 4'd9 : 4'd5;
    end
    // immediate following the displacement
    imm_pos = 3'd2 + {1'b0, dl};
    imm_lo  = pick(bv, imm_pos);
    imm_hi  = pick(bv, imm_pos + 3'd1);
    imm_w   = {imm_hi, imm_lo};
    imm_rm  = w ? imm_w : sext8(imm_lo);
    imm_acc = w ? {third_byte, second_byte} : sext8(second_byte);

    len = 3'd1;  cyc = 5'd0;
    wr = 1'b0;   num = 3'd0;  val = 16'h0000;
    load = 1'b0; store = 1'b0; st_data = 16'h0000;
    jump = 16'h0000; unk = 1'b0;
    alu_en = 1'b0; alu_kind = ALU_ADD; alu_dst = 3'd0; alu_b = 16'h0000;

    priority if (op[7:2] == OP_MOV_RM) begin
      len = 3'd2 + {1'b0, dl};
      if (md == 2'd3) begin
        wr  = 1'b1;
        num = d ? ri : rm;
        val = d ? regs[rm] : regs[ri];
        cyc = 5'd2;
      end else if (d) begin
        wr   = 1'b1;
        num  = ri;
        load = 1'b1;
        cyc  = {1'b0, eac} + 5'd8;
      end else begin
        store   = 1'b1;
        st_data = regs[ri];
        cyc     = {1'b0, eac} + 5'd9;
      end
    end else if (op[7:1] == OP_MOV_IMM) begin
      // reg field ignored
      len = 3'd2 + {1'b0, dl} + (w ? 3'd2 : 3'd1);
      if (md == 2'd3) begin
        wr  = 1'b1;
        num = rm;
        val = imm_rm;
        cyc = 5'd4;
      end else begin
        store   = 1'b1;
        st_data = imm_rm;
        cyc     = {1'b0, eac} + 5'd10;
      end
    end else if (op[7:4] == OP_MOV_RI) begin
      wr  = 1'b1;
      num = op[3] ? op[2:0] : {1'b0, op[1:0]};
      val = op[3] ? {third_byte, second_byte} : sext8(second_byte);
      len = op[3] ? 3'd3 : 3'd2;
      cyc = 5'd4;
    end else if (op[7:2] == OP_MOV_ACC) begin
      len = 3'd3;
      cyc = 5'd10;
    end else if (op[7:6] == 2'd0 && op[2] == 1'b0) begin
      // memory forms act on the r/m register
      len      = 3'd2 + {1'b0, dl};
      alu_en   = 1'b1;
      alu_kind = op[5:3];
      alu_dst  = d ? ri : rm;
      alu_b    = d ? regs[rm] : regs[ri];
      cyc      = (md == 2'd3) ? 5'd3 : ({1'b0, eac} + (d ? 5'd9 : 5'd16));
    end else if (op[7:2] == OP_ALU_IMM) begin
      len      = 3'd2 + {1'b0, dl} + ((w && !d) ? 3'd2 : 3'd1);
      alu_en   = 1'b1;
      alu_kind = rg;
      alu_dst  = rm;
      alu_b    = (w && !d) ? imm_w : sext8(imm_lo);
      cyc      = (md == 2'd3) ? 5'd4 : ({1'b0, eac} + 5'd17);
    end else if (op[7:6] == 2'd0 && op[2:1] == 2'd2) begin
      len      = w ? 3'd3 : 3'd2;
      alu_en   = 1'b1;
      alu_kind = op[5:3];
      alu_dst  = 3'd0;
      alu_b    = imm_acc;
      cyc      = 5'd4;
    end else if (op[7:4] == OP_JCC) begin
      len = 3'd2;
      if (op[3:0] == OP_JNE && !zero_out) begin
        jump = sext8(second_byte);
      end
    end else if (op[7:4] == OP_LOOP && op[3:2] == 2'd0) begin
      len = 3'd2;
    end else begin
      unk = 1'b1;
    end

    // shared adder for add, sub and cmp
    alu_a   = regs[alu_dst];
    alu_res = (alu_kind == ALU_ADD) ? alu_a + alu_b : alu_a - alu_b;
    sign_n  = sign_out;
    zero_n  = zero_out;
    if (alu_en && (alu_kind == ALU_ADD || alu_kind == ALU_SUB)) begin
      wr  = 1'b1;
      num = alu_dst;
      val = alu_res;
    end
    if (alu_en && (alu_kind == ALU_ADD || alu_kind == ALU_SUB || alu_kind == ALU_CMP)) begin
      sign_n = alu_res[15];
      zero_n = (alu_res == 16'h0000);
    end
  end

  // ---------------------------------------------------------------- data store
  always_comb begin
    // second byte address wraps at 16 bits before it is cut to the store size
    lo_addr = ADDR_W'(ea);
    hi_addr = ADDR_W'(16'(ea + 16'd1));
    if (st == ST_CLEAR) begin
      even_row   = clear_row;
      odd_row    = clear_row;
      even_we    = 1'b1;
      odd_we     = 1'b1;
      even_wdata = 8'h00;
      odd_wdata  = 8'h00;
    end else begin
      even_row   = lo_addr[0] ? hi_addr[ADDR_W-1:1] : lo_addr[ADDR_W-1:1];
      odd_row    = lo_addr[0] ? lo_addr[ADDR_W-1:1] : hi_addr[ADDR_W-1:1];
      even_we    = accept && store;
      odd_we     = accept && store;
      even_wdata = lo_addr[0] ? st_data[15:8] : st_data[7:0];
      odd_wdata  = lo_addr[0] ? st_data[7:0]  : st_data[15:8];
    end
  end

  // read data is taken only at accept and held through a stalled finish
  always_ff @(posedge clk) begin
    if (even_we) begin
      bank_even[even_row] <= even_wdata;
    end
    if (accept) begin
      even_rdata <= bank_even[even_row];
    end
  end

  always_ff @(posedge clk) begin
    if (odd_we) begin
      bank_odd[odd_row] <= odd_wdata;
    end
    if (accept) begin
      odd_rdata <= bank_odd[odd_row];
    end
  end

  // ---------------------------------------------------------------- finish
  assign load_val = p_a0 ? {even_rdata, odd_rdata} : {odd_rdata, even_rdata};
  assign wb_val   = p_load ? load_val : p_val;

  always_ff @(posedge clk) begin
    if (accept) begin
      p_wr   <= wr;
      p_num  <= num;
      p_val  <= val;
      p_load <= load;
      p_a0   <= lo_addr[0];
      p_sign <= sign_n;
      p_zero <= zero_n;
      p_ptr  <= next_pointer + {13'd0, len} + jump;
      p_cyc  <= cyc;
      p_len  <= len;
      p_unk  <= unk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_CLEAR;
      clear_row    <= '0;
      out_valid    <= 1'b0;
      next_pointer <= 16'h0000;
      sign_out     <= 1'b0;
      zero_out     <= 1'b0;
      cycle_total  <= 32'd0;
      for (int i = 0; i < 8; i++) begin
        regs[i] <= 16'h0000;
      end
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_CLEAR: begin
          clear_row <= clear_row + 1'b1;
          if (clear_row == {ROW_W{1'b1}}) begin
            st <= ST_ACCEPT;
          end
        end
        ST_ACCEPT: begin
          if (accept) begin
            st <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (commit) begin
            st           <= ST_ACCEPT;
            out_valid    <= 1'b1;
            next_pointer <= p_ptr;
            sign_out     <= p_sign;
            zero_out     <= p_zero;
            cycle_total  <= cycle_total + {27'd0, p_cyc};
            if (p_wr) begin
              regs[p_num] <= wb_val;
            end
          end
        end
        default: st <= ST_CLEAR;
      endcase
    end
  end

  // result word fields that only change at commit
  always_ff @(posedge clk) begin
    if (commit) begin
      length_used    <= p_len;
      reg_written    <= p_wr;
      reg_number     <= p_wr ? p_num : 3'd0;
      reg_value      <= p_wr ? wb_val : 16'h0000;
      unknown_opcode <= p_unk;
    end
  end

`ifndef SYNTHESIS
  // an accepted word always goes to the finish stage next
  a_accept_to_finish: assert property (@(posedge clk) disable iff (rst)
    accept |=> (st == ST_FINISH))
    else $error("accepted word did not reach finish stage");

  // no word is taken while the store sweep is running
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (st == ST_CLEAR) |-> in_stall)
    else $error("input taken during store clear");

  // a result word appears only out of the finish stage
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st == ST_FINISH))
    else $error("result word without finish stage");
`endif

endmodule

[dv/x86es_checker.sv]
// ----------------------------------------------------------------------------
// x86es_checker
// watches both channels of the execute step, predicts each result word from
// its own copy of registers, flags, pointer, cycle count and data store, and
// compares field by field in order
// ----------------------------------------------------------------------------
module x86es_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  opcode_byte,
  input  logic [7:0]  second_byte,
  input  logic [7:0]  third_byte,
  input  logic [7:0]  fourth_byte,
  input  logic [7:0]  fifth_byte,
  input  logic [7:0]  sixth_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] next_pointer,
  input  logic [2:0]  length_used,
  input  logic        reg_written,
  input  logic [2:0]  reg_number,
  input  logic [15:0] reg_value,
  input  logic        sign_out,
  input  logic        zero_out,
  input  logic [31:0] cycle_total,
  input  logic        unknown_opcode,
  output int          fail_count,
  output int          pending
);
  import x86es_pkg::*;

  typedef struct packed {
    logic [15:0] ptr;
    logic [2:0]  len;
    logic        wr;
    logic [2:0]  num;
    logic [15:0] val;
    logic        sf;
    logic        zf;
    logic [31:0] cyc;
    logic        unk;
  } step_result_t;

  step_result_t expected_steps[$];
  logic [15:0] gpr [8];
  logic [7:0]  mem [65536];
  logic        sf_q, zf_q;
  logic [15:0] ip_q;
  logic [31:0] cyc_q;
  logic        wr_q;
  logic [2:0]  num_q;
  logic [15:0] val_q;

  assign pending = expected_steps.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  function automatic int disp_bytes(input logic [1:0] md, input logic [2:0] rm);
    if (md == 2'd1) return 1;
    if (md == 2'd2 || (md == 2'd0 && rm == 3'd6)) return 2;
    return 0;
  endfunction

  function automatic logic [15:0] imm_at(input logic [7:0] b[6], input int pos,
                                        input logic wide);
    if (wide) return {b[pos+1], b[pos]};
    return {{8{b[pos][7]}}, b[pos]};
  endfunction

  function automatic logic [15:0] ea(input logic [1:0] md, input logic [2:0] rm,
                                     input logic [15:0] dsp);
    logic [15:0] base;
    if (md == 2'd0 && rm == 3'd6) return dsp;
    case (rm)
      3'd0: base = gpr[3] + gpr[6];
      3'd1: base = gpr[3] + gpr[7];
      3'd2: base = gpr[5] + gpr[6];
      3'd3: base = gpr[5] + gpr[7];
      3'd4: base = gpr[6];
      3'd5: base = gpr[7];
      3'd6: base = gpr[5];
      default: base = gpr[3];
    endcase
    return base + dsp;
  endfunction

  function automatic int ea_cost(input logic [1:0] md, input logic [2:0] rm,
                                 input logic [15:0] dsp);
    logic has;
    has = dsp != 0;
    if (md == 2'd0 && rm == 3'd6) return 6;
    if (rm == 3'd0 || rm == 3'd3) return has ? 11 : 7;
    if (rm == 3'd1 || rm == 3'd2) return has ? 12 : 8;
    return has ? 9 : 5;
  endfunction

  function automatic void write_gpr(input logic [2:0] r, input logic [15:0] v);
    gpr[r] = v;
    wr_q = 1'b1;
    num_q = r;
    val_q = v;
  endfunction

  function automatic void flags_from(input logic [15:0] v);
    sf_q = v[15];
    zf_q = (v == 16'h0);
  endfunction

  function automatic void alu(input logic [2:0] kind, input logic [2:0] dst,
                              input logic [15:0] v);
    logic [15:0] r;
    if (kind == ALU_ADD) begin
      r = gpr[dst] + v; write_gpr(dst, r); flags_from(r);
    end else if (kind == ALU_SUB) begin
      r = gpr[dst] - v; write_gpr(dst, r); flags_from(r);
    end else if (kind == ALU_CMP) begin
      flags_from(gpr[dst] - v);
    end
  endfunction

  // executes one instruction on the shadow state and returns the result word
  function automatic step_result_t execute_instruction(input logic [7:0] b[6]);
    step_result_t s;
    logic [7:0] op;
    logic d, w, wide, unk;
    logic [1:0] md;
    logic [2:0] rg, rm, ri;
    logic [15:0] dsp, a, jmp, dat;
    int len, cost, dl;
    op = b[0]; d = op[1]; w = op[0];
    md = b[1][7:6]; rg = b[1][5:3]; rm = b[1][2:0];
    ri = w ? rg : {1'b0, rg[1:0]};
    dl = disp_bytes(md, rm);
    dsp = (dl == 0) ? 16'h0 : imm_at(b, 2, dl == 2);
    len = 1; cost = 0; jmp = 16'h0; unk = 1'b0;
    wr_q = 1'b0; num_q = 3'd0; val_q = 16'h0;
    if (op[7:2] == OP_MOV_RM) begin
      len = 2 + dl;
      if (md == 2'd3) begin
        if (!d) write_gpr(rm, gpr[ri]);
        else write_gpr(ri, gpr[rm]);
        cost = 2;
      end else begin
        a = ea(md, rm, dsp);
        if (d) write_gpr(ri, {mem[a + 16'd1], mem[a]});
        else begin
          mem[a] = gpr[ri][7:0];
          mem[a + 16'd1] = gpr[ri][15:8];
        end
        cost = ea_cost(md, rm, dsp) + (d ? 8 : 9);
      end
    end else if (op[7:1] == OP_MOV_IMM) begin
      dat = imm_at(b, 2 + dl, w);
      len = 2 + dl + (w ? 2 : 1);
      if (md == 2'd3) begin
        write_gpr(rm, dat); cost = 4;
      end else begin
        a = ea(md, rm, dsp);
        mem[a] = dat[7:0];
        mem[a + 16'd1] = dat[15:8];
        cost = ea_cost(md, rm, dsp) + 10;
      end
    end else if (op[7:4] == OP_MOV_RI) begin
      wide = op[3];
      write_gpr(wide ? op[2:0] : {1'b0, op[1:0]}, imm_at(b, 1, wide));
      len = wide ? 3 : 2;
      cost = 4;
    end else if (op[7:2] == OP_MOV_ACC) begin
      len = 3; cost = 10;
    end else if (op[7:6] == 2'd0 && !op[2]) begin
      len = 2 + dl;
      alu(op[5:3], d ? ri : rm, gpr[d ? rm : ri]);
      cost = (md == 2'd3) ? 3 : ea_cost(md, rm, dsp) + (d ? 9 : 16);
    end else if (op[7:2] == OP_ALU_IMM) begin
      wide = w && !d;
      len = 2 + dl + (wide ? 2 : 1);
      alu(rg, rm, imm_at(b, 2 + dl, wide));
      cost = (md == 2'd3) ? 4 : ea_cost(md, rm, dsp) + 17;
    end else if (op[7:6] == 2'd0 && op[2:1] == 2'd2) begin
      len = w ? 3 : 2;
      alu(op[5:3], 3'd0, imm_at(b, 1, w));
      cost = 4;
    end else if (op[7:4] == OP_JCC) begin
      len = 2;
      if (op[3:0] == OP_JNE && !zf_q) jmp = {{8{b[1][7]}}, b[1]};
    end else if (op[7:4] == OP_LOOP && op[3:2] == 2'd0) begin
      len = 2;
    end else begin
      unk = 1'b1;
    end
    ip_q = ip_q + 16'(len) + jmp;
    cyc_q = cyc_q + 32'(cost);
    s.ptr = ip_q; s.len = 3'(len); s.wr = wr_q; s.num = num_q; s.val = val_q;
    s.sf = sf_q; s.zf = zf_q; s.cyc = cyc_q; s.unk = unk;
    return s;
  endfunction

  always @(posedge clk) begin
    step_result_t e;
    logic [7:0] b[6];
    if (rst) begin
      fail_count = 0;
      expected_steps.delete();
      foreach (gpr[i]) gpr[i] = 16'h0;
      foreach (mem[i]) mem[i] = 8'h0;
      sf_q = 1'b0; zf_q = 1'b0; ip_q = 16'h0; cyc_q = 32'd0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_steps.size() == 0) begin
          $display("unexpected result word");
          fail_count++;
        end else begin
          e = expected_steps.pop_front();
          if (next_pointer !== e.ptr)
            report("next_pointer", 32'(next_pointer), 32'(e.ptr));
          if (length_used !== e.len)
            report("length_used", 32'(length_used), 32'(e.len));
          if (reg_written !== e.wr)
            report("reg_written", 32'(reg_written), 32'(e.wr));
          if (reg_number !== e.num)
            report("reg_number", 32'(reg_number), 32'(e.num));
          if (reg_value !== e.val)
            report("reg_value", 32'(reg_value), 32'(e.val));
          if (sign_out !== e.sf)
            report("sign_out", 32'(sign_out), 32'(e.sf));
          if (zero_out !== e.zf)
            report("zero_out", 32'(zero_out), 32'(e.zf));
          if (cycle_total !== e.cyc)
            report("cycle_total", cycle_total, e.cyc);
          if (unknown_opcode !== e.unk)
            report("unknown_opcode", 32'(unknown_opcode), 32'(e.unk));
        end
      end
      if (in_valid && !in_stall) begin
        b = '{opcode_byte, second_byte, third_byte, fourth_byte, fifth_byte, sixth_byte};
        expected_steps.push_back(execute_instruction(b));
      end
    end
  end
endmodule

[dv/tb_x86_16bit_subset_execute_step.sv]
// ----------------------------------------------------------------------------
// tb_x86_16bit_subset_execute_step
// drives directed and random instruction words into the execute step under
// random idling and a long output hold-off; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_x86_16bit_subset_execute_step;
  import x86es_pkg::*;

  localparam int N_RANDOM = 700;
  // clear sweep after reset runs over 32768 rows per bank, so the stall limit sits above it
  localparam int IDLE_LIMIT = 100000;

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [7:0]  opcode_byte, second_byte, third_byte, fourth_byte, fifth_byte, sixth_byte;
  logic [15:0] next_pointer, reg_value;
  logic [2:0]  length_used, reg_number;
  logic        reg_written, sign_out, zero_out, unknown_opcode;
  logic [31:0] cycle_total;
  int          fail_count, pending;
  logic        idling_on;   // random gaps enabled on both sides
  logic        hold_off;    // long receiver stall request
  int          quiet_cycles = 0;

  x86_16bit_subset_execute_step uut (.*);

  x86es_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog: cycles with no word accepted on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stall bursts, or a long hold-off when asked
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1;
        repeat (60) @(negedge clk);
        out_stall <= 0;
        hold_off = 0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 18);
        out_stall <= 1;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall <= 0;
      end
    end
  end

  // offers one instruction word and waits until it is taken
  task automatic send_instruction(input logic [7:0] b0, b1, b2, b3, b4, b5);
    int n;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 18);
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1;
    opcode_byte <= b0; second_byte <= b1; third_byte <= b2;
    fourth_byte <= b3; fifth_byte <= b4; sixth_byte <= b5;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_bytes(input logic [7:0] op);
    send_instruction(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom));
  endtask

  // picks an opcode weighted toward the supported groups
  function automatic logic [7:0] pick_opcode();
    logic [7:0] op;
    case ($urandom_range(0, 9))
      0, 1: op = {OP_MOV_RM, 2'($urandom)};
      2:    op = {OP_MOV_IMM, 1'($urandom)};
      3:    op = {OP_MOV_RI, 4'($urandom)};
      4:    op = {OP_ALU_IMM, 2'($urandom)};
      5:    op = {2'b00, 3'($urandom), 1'b0, 2'($urandom)};
      6:    op = {2'b00, 3'($urandom), 2'b10, 1'($urandom)};
      7:    op = {OP_JCC, ($urandom_range(0, 1) ? OP_JNE : 4'($urandom))};
      8:    op = {OP_LOOP, 4'($urandom_range(0, 3))};
      default: op = 8'($urandom);
    endcase
    return op;
  endfunction

  initial begin
    rst = 1; in_valid = 0; idling_on = 0; hold_off = 0;
    {opcode_byte, second_byte, third_byte, fourth_byte, fifth_byte, sixth_byte} = '0;
    repeat (11) @(negedge clk);
    rst = 0;

    // directed: immediates at the extremes, word moves, several addressing modes
    send_instruction(8'hB8, 8'hFF, 8'hFF, 0, 0, 0);         // mov ax,ffff
    send_instruction(8'hBB, 8'h00, 8'h80, 0, 0, 0);         // mov bx,8000
    send_instruction(8'hB6, 8'h7F, 0, 0, 0, 0);             // byte reg maps to dx
    send_instruction(8'hBE, 8'hFF, 8'hFF, 0, 0, 0);         // si=ffff, wraps addresses
    send_instruction(8'h89, 8'h00, 0, 0, 0, 0);             // [bx+si] <- ax
    send_instruction(8'h8B, 8'h08, 0, 0, 0, 0);             // cx <- [bx+si]
    send_instruction(8'h89, 8'h06, 8'hFF, 8'hFF, 0, 0);     // direct store at ffff wraps
    send_instruction(8'h8B, 8'h16, 8'hFF, 8'hFF, 0, 0);     // direct load
    send_instruction(8'h8B, 8'h46, 8'h80, 0, 0, 0);         // bp+disp8 negative
    send_instruction(8'h89, 8'h87, 8'h34, 8'h12, 0, 0);     // bx+disp16
    send_instruction(8'h88, 8'hC1, 0, 0, 0, 0);             // reg-reg byte form
    send_instruction(8'hC7, 8'hF6, 8'h10, 8'h00, 8'hCD, 8'hAB); // reg field ignored
    send_instruction(8'hC6, 8'h47, 8'h02, 8'h80, 0, 0);     // byte imm sign-extended
    send_instruction(8'hC7, 8'hC3, 8'h01, 8'h00, 0, 0);     // mov bx,1 register form
    send_instruction(8'h01, 8'hC0, 0, 0, 0, 0);             // add ax,ax
    send_instruction(8'h29, 8'hC0, 0, 0, 0, 0);             // sub ax,ax -> zero
    send_instruction(8'h3B, 8'h46, 8'h04, 0, 0, 0);         // cmp memory form on reg
    send_instruction(8'h83, 8'hC1, 8'hFF, 0, 0, 0);         // add cx,-1
    send_instruction(8'h81, 8'hF9, 8'h00, 8'h80, 0, 0);     // cmp cx,8000
    send_instruction(8'h81, 8'h8F, 8'h01, 8'h00, 8'h02, 8'h00); // or, memory: no change
    send_instruction(8'h05, 8'hFF, 8'h7F, 0, 0, 0);         // add ax,7fff
    send_instruction(8'h3C, 8'hFF, 0, 0, 0, 0);             // cmp al imm8
    send_instruction(8'h75, 8'h80, 0, 0, 0, 0);             // jne back, taken
    send_instruction(8'hA1, 8'h00, 8'h00, 0, 0, 0);         // accumulator move
    send_instruction(8'hE2, 8'hFE, 0, 0, 0, 0);             // loop only advances
    send_instruction(8'hF4, 0, 0, 0, 0, 0);                 // unknown

    // random: mostly supported groups, with random gaps and one long hold-off
    idling_on = 1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 200) hold_off = 1;
      if (i == N_RANDOM - 100) idling_on = 0;
      send_random_bytes(pick_opcode());
    end
    in_valid <= 0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
